// ----- rtl/knn_pkg.sv -----
// ----------------------------------------------------------------------------
// knn_pkg
// shared constants, command and status types of the nearest neighbor classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package knn_pkg;

	localparam int STORE_DEPTH    = 1024;
	localparam int NUM_CLASSES    = 16;
	localparam int MAX_NEIGHBOURS = 16;
	localparam int K_RESET        = 5;
	localparam int QUEUE_DEPTH    = 4;

	localparam int FEAT_W  = 16;
	localparam int LABEL_W = 4;
	localparam int K_W     = 5;
	localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
	localparam int SLOT_W  = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
	localparam int CLS_W   = $clog2(NUM_CLASSES);
	localparam int VOTE_W  = $clog2(MAX_NEIGHBOURS + 1);
	localparam int QPTR_W  = $clog2(QUEUE_DEPTH);

	// action codes on the input stream
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_LOAD  = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	typedef enum logic [1:0] {
		CMD_CLEAR,
		CMD_LOAD,
		CMD_QUERY
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [FEAT_W-1:0]   feature;
		logic [LABEL_W-1:0]  label;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} queue_stat_t;

	typedef struct packed {
		logic [CLS_W-1:0]  cls;
		logic              has_answer;
		logic [VOTE_W-1:0] votes;
	} result_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_FLUSH,
		BK_VOTE,
		BK_PICK,
		BK_OUT
	} bk_state_t;

endpackage

// ----- rtl/knn_classifier_1d.sv -----
// ----------------------------------------------------------------------------
// knn_classifier_1d
// k nearest neighbor classifier on one 16-bit feature
// ----------------------------------------------------------------------------
// Items arrive on the slave stream with the action in tuser: clear empties the
// training store, load appends a feature and class label (dropped when the
// 1024-entry store is full), query finds the k stored entries closest to its
// feature by absolute difference and lets their labels vote. Each query gives
// one result transfer; clear and load give none, and action 3 is dropped.
// Distance ties go to the earlier loaded entry, vote ties to the lowest class,
// and an empty store answers with has_answer low and zero fields. k comes from
// the cfg port (reset 5, zero acts as one, above 16 saturates to 16) and must
// only be written while the block is idle. A front decoder feeds a four-deep
// command queue, so the input keeps taking transfers, until the queue is full,
// while the back end is busy or a result waits on the master side. In the back
// end a query scans the store through its single read port, one entry per
// cycle, into a sorted list of the k closest, then the list is counted slot by
// slot into per-class votes and the classes are searched one by one for the
// winner. There is no clearing pass after reset; the fill count alone marks
// valid store entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module knn_classifier_1d
	import knn_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	// configuration
	input  logic           cfg_we,
	input  logic [K_W-1:0] cfg_wdata,      // neighbour_count
	// input stream
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  logic [23:0]    s_axis_tdata,   // feature_value[15:0], class_label[19:16]
	input  logic [1:0]     s_axis_tuser,   // action[1:0]
	// result stream
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [15:0]    m_axis_tdata,   // predicted_class[3:0], winning_votes[8:4]
	output logic           m_axis_tuser    // has_answer
);

	logic [K_W-1:0] k_q;
	queue_stat_t    q_stat;
	logic           push;
	cmd_t           push_cmd;
	logic           pop;
	cmd_t           head_cmd;
	result_t        res;

	// neighbor count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) k_q <= K_W'(K_RESET);
		else if (cfg_we) k_q <= cfg_wdata;
	end

	knn_front u_front (
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_tdata  (s_axis_tdata),
		.s_tuser  (s_axis_tuser),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	knn_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.stat     (q_stat)
	);

	knn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.k_cfg     (k_q),
		.cmd_valid (q_stat.nonempty),
		.cmd       (head_cmd),
		.pop       (pop),
		.res_valid (m_axis_tvalid),
		.res       (res),
		.res_ready (m_axis_tready)
	);

	// result transfer packing, zero padded to two bytes
	assign m_axis_tdata = {{(16 - CLS_W - VOTE_W){1'b0}}, res.votes, res.cls};
	assign m_axis_tuser = res.has_answer;

	// a command is never pushed into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !q_stat.full)
		else $error("command pushed into full queue");

	// an empty-store answer carries zero class and votes
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("empty-store result with nonzero fields");

	// a real answer has at least one and at most the maximum number of votes
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |->
		(res.votes != '0 && int'(res.votes) <= MAX_NEIGHBOURS))
		else $error("winning vote count out of range");

	// the queue is only popped while it holds a command
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> q_stat.nonempty)
		else $error("pop from empty queue");

endmodule

// ----- rtl/knn_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// knn_cmd_queue
// short command queue between the front decoder and the back executor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module knn_cmd_queue
	import knn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  cmd_t        push_cmd,
	input  logic        pop,
	output cmd_t        head_cmd,
	output queue_stat_t stat
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;
	logic              do_push;
	logic              do_pop;

	assign stat.full     = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign stat.nonempty = (fill_q != '0);
	assign do_push       = push && !stat.full;
	assign do_pop        = pop && stat.nonempty;
	assign head_cmd      = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) fill_q <= fill_q + 1'b1;
			else if (!do_push && do_pop) fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ----- rtl/knn_front.sv -----
// ----------------------------------------------------------------------------
// knn_front
// accepts input transfers, decodes the action and queues a command
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module knn_front
	import knn_pkg::*;
(
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  queue_stat_t q_stat,
	output logic        push,
	output cmd_t        push_cmd
);

	logic accepted;
	logic label_ok;

	assign s_tready = !q_stat.full;
	assign accepted = s_tvalid && s_tready;
	assign label_ok = (int'(s_tdata[FEAT_W +: LABEL_W]) < NUM_CLASSES);

	always_comb begin
		push             = 1'b0;
		push_cmd.kind    = CMD_CLEAR;
		push_cmd.feature = s_tdata[FEAT_W-1:0];
		push_cmd.label   = s_tdata[FEAT_W +: LABEL_W];
		case (s_tuser)
			ACT_CLEAR: begin
				push = accepted;
			end
			ACT_LOAD: begin
				// labels outside the class range are dropped here
				push          = accepted && label_ok;
				push_cmd.kind = CMD_LOAD;
			end
			ACT_QUERY: begin
				push          = accepted;
				push_cmd.kind = CMD_QUERY;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

endmodule

// ----- rtl/knn_back.sv -----
// ----------------------------------------------------------------------------
// knn_back
// training store, distance scan with sorted neighbor list, vote and result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module knn_back
	import knn_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic [K_W-1:0] k_cfg,
	input  logic           cmd_valid,
	input  cmd_t           cmd,
	output logic           pop,
	output logic           res_valid,
	output result_t        res,
	input  logic           res_ready
);

	bk_state_t state_q;
	bk_state_t state_d;

	logic [FEAT_W+LABEL_W-1:0] store_mem [STORE_DEPTH];

	logic [CNT_W-1:0]   count_q;
	logic [ADDR_W-1:0]  rd_idx_q;
	logic [FEAT_W-1:0]  query_q;
	logic               has_q;
	logic [SLOT_W-1:0]  slot_idx_q;
	logic [CLS_W-1:0]   cls_idx_q;
	logic [CLS_W-1:0]   win_cls_q;
	logic [VOTE_W-1:0]  win_votes_q;
	logic [VOTE_W-1:0]  votes_q [NUM_CLASSES];

	logic                      rd_v_s1;
	logic [FEAT_W+LABEL_W-1:0] rd_data_s1;
	logic                      v_s2;
	logic [FEAT_W-1:0]         dist_s2;
	logic [LABEL_W-1:0]        lab_s2;

	logic [FEAT_W-1:0]  slot_d_q   [MAX_NEIGHBOURS];
	logic [LABEL_W-1:0] slot_lab_q [MAX_NEIGHBOURS];
	logic               slot_v_q   [MAX_NEIGHBOURS];
	logic [FEAT_W-1:0]  ins_d      [MAX_NEIGHBOURS];
	logic [LABEL_W-1:0] ins_lab    [MAX_NEIGHBOURS];
	logic               ins_v      [MAX_NEIGHBOURS];

	logic [K_W-1:0]     k_eff;
	logic [FEAT_W-1:0]  feat_s1;
	logic [FEAT_W-1:0]  dist_s1;
	logic               store_we;
	logic               start_query;
	logic               load_res;
	logic               scan_last;

	// k of zero acts as one, large k saturates
	always_comb begin
		if (k_cfg == '0) k_eff = K_W'(1);
		else if (int'(k_cfg) > MAX_NEIGHBOURS) k_eff = K_W'(MAX_NEIGHBOURS);
		else k_eff = k_cfg;
	end

	assign scan_last = (CNT_W'(rd_idx_q) == count_q - 1'b1);
	assign feat_s1   = rd_data_s1[FEAT_W-1:0];
	assign dist_s1   = (feat_s1 >= query_q) ? (feat_s1 - query_q) : (query_q - feat_s1);

	// next state and control
	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		store_we    = 1'b0;
		start_query = 1'b0;
		load_res    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					pop = 1'b1;
					case (cmd.kind)
						CMD_LOAD: begin
							store_we = (count_q < CNT_W'(STORE_DEPTH));
						end
						CMD_QUERY: begin
							start_query = 1'b1;
							state_d     = (count_q == '0) ? BK_OUT : BK_SCAN;
						end
						default: begin
							state_d = BK_IDLE;
						end
					endcase
				end
			end
			BK_SCAN: begin
				if (scan_last) state_d = BK_FLUSH;
			end
			BK_FLUSH: begin
				if (!rd_v_s1 && !v_s2) state_d = BK_VOTE;
			end
			BK_VOTE: begin
				if (slot_idx_q == SLOT_W'(MAX_NEIGHBOURS - 1)) state_d = BK_PICK;
			end
			BK_PICK: begin
				if (cls_idx_q == CLS_W'(NUM_CLASSES - 1)) state_d = BK_OUT;
			end
			BK_OUT: begin
				if (!res_valid || res_ready) begin
					load_res = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// insert the new distance behind every held entry that is no farther
	always_comb begin
		logic               prev_ge;
		logic [FEAT_W-1:0]  prev_d;
		logic [LABEL_W-1:0] prev_lab;
		logic               prev_v;
		logic               ge;
		logic               en;
		prev_ge  = 1'b1;
		prev_d   = '0;
		prev_lab = '0;
		prev_v   = 1'b0;
		for (int p = 0; p < MAX_NEIGHBOURS; p++) begin
			ge = slot_v_q[p] && (slot_d_q[p] <= dist_s2);
			en = (p < int'(k_eff));
			if (ge) begin
				ins_d[p]   = slot_d_q[p];
				ins_lab[p] = slot_lab_q[p];
				ins_v[p]   = 1'b1;
			end else if (prev_ge) begin
				ins_d[p]   = dist_s2;
				ins_lab[p] = lab_s2;
				ins_v[p]   = en;
			end else begin
				ins_d[p]   = prev_d;
				ins_lab[p] = prev_lab;
				ins_v[p]   = prev_v && en;
			end
			prev_ge  = ge;
			prev_d   = slot_d_q[p];
			prev_lab = slot_lab_q[p];
			prev_v   = slot_v_q[p];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else state_q <= state_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rd_v_s1   <= 1'b0;
			v_s2      <= 1'b0;
			res_valid <= 1'b0;
			for (int p = 0; p < MAX_NEIGHBOURS; p++) slot_v_q[p] <= 1'b0;
		end else begin
			if (state_q == BK_IDLE && cmd_valid && cmd.kind == CMD_CLEAR) count_q <= '0;
			else if (store_we) count_q <= count_q + 1'b1;
			rd_v_s1 <= (state_q == BK_SCAN);
			v_s2    <= rd_v_s1;
			if (start_query) begin
				for (int p = 0; p < MAX_NEIGHBOURS; p++) slot_v_q[p] <= 1'b0;
			end else if (v_s2) begin
				for (int p = 0; p < MAX_NEIGHBOURS; p++) slot_v_q[p] <= ins_v[p];
			end
			if (load_res) res_valid <= 1'b1;
			else if (res_ready) res_valid <= 1'b0;
		end
	end

	// training store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (store_we) store_mem[count_q[ADDR_W-1:0]] <= {cmd.label, cmd.feature};
		rd_data_s1 <= store_mem[rd_idx_q];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		dist_s2 <= dist_s1;
		lab_s2  <= rd_data_s1[FEAT_W +: LABEL_W];
		if (start_query) begin
			query_q     <= cmd.feature;
			has_q       <= (count_q != '0);
			rd_idx_q    <= '0;
			slot_idx_q  <= '0;
			cls_idx_q   <= '0;
			win_cls_q   <= '0;
			win_votes_q <= '0;
			for (int c = 0; c < NUM_CLASSES; c++) votes_q[c] <= '0;
		end
		if (state_q == BK_SCAN) rd_idx_q <= rd_idx_q + 1'b1;
		if (v_s2) begin
			for (int p = 0; p < MAX_NEIGHBOURS; p++) begin
				slot_d_q[p]   <= ins_d[p];
				slot_lab_q[p] <= ins_lab[p];
			end
		end
		if (state_q == BK_VOTE) begin
			slot_idx_q <= slot_idx_q + 1'b1;
			if (slot_v_q[slot_idx_q]) begin
				votes_q[slot_lab_q[slot_idx_q]] <= votes_q[slot_lab_q[slot_idx_q]] + 1'b1;
			end
		end
		if (state_q == BK_PICK) begin
			cls_idx_q <= cls_idx_q + 1'b1;
			// strict compare keeps the lowest class on a tie
			if (votes_q[cls_idx_q] > win_votes_q) begin
				win_votes_q <= votes_q[cls_idx_q];
				win_cls_q   <= cls_idx_q;
			end
		end
		if (load_res) begin
			res.cls        <= win_cls_q;
			res.has_answer <= has_q;
			res.votes      <= win_votes_q;
		end
	end

endmodule
